// ===== rtl/crcfc_pkg.sv =====
`default_nettype none

package crcfc_pkg;

  localparam logic [7:0]  START_BYTE  = 8'h02;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [8:0]  MAX_PAYLOAD = 9'd256;

  localparam logic ACT_BYTE    = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  localparam logic [1:0] ST_GOOD       = 2'd0;
  localparam logic [1:0] ST_BAD_HEADER = 2'd1;
  localparam logic [1:0] ST_BAD_CRC    = 2'd2;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_ZERO_A = 3'd1,
    PH_ZERO_B = 3'd2,
    PH_LEN    = 3'd3,
    PH_DATA   = 3'd4,
    PH_CRC_HI = 3'd5,
    PH_CRC_LO = 3'd6
  } phase_t;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       frame_done;
    logic [1:0] frame_status;
  } out_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int k = 7; k >= 0; k--) begin
      fb = c[15] ^ b[k];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/crcfc_fsm.sv =====
`default_nettype none

module crcfc_fsm (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           step,
  input  wire crcfc_pkg::in_t item,
  output crcfc_pkg::out_t     res
);
  import crcfc_pkg::*;

  phase_t      phase, phase_next;
  logic [8:0]  byte_count, byte_count_next;
  logic [8:0]  payload_length, payload_length_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  crc_high_received, crc_high_received_next;
  logic        header_bad, header_bad_next;

  logic [7:0]  b;
  logic [15:0] crc_upd;
  logic [8:0]  count_inc;

  assign b         = item.rx_byte;
  assign crc_upd   = crc_byte(running_crc, b);
  assign count_inc = byte_count + 9'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HUNT;
      byte_count        <= '0;
      payload_length    <= '0;
      running_crc       <= '0;
      crc_high_received <= '0;
      header_bad        <= 1'b0;
    end else if (step) begin
      phase             <= phase_next;
      byte_count        <= byte_count_next;
      payload_length    <= payload_length_next;
      running_crc       <= running_crc_next;
      crc_high_received <= crc_high_received_next;
      header_bad        <= header_bad_next;
    end
  end

  always_comb begin
    phase_next             = phase;
    byte_count_next        = byte_count;
    payload_length_next    = payload_length;
    running_crc_next       = running_crc;
    crc_high_received_next = crc_high_received;
    header_bad_next        = header_bad;
    res                    = '0;
    if (item.action == ACT_RESTART) begin
      phase_next             = PH_HUNT;
      byte_count_next        = '0;
      payload_length_next    = '0;
      running_crc_next       = '0;
      crc_high_received_next = '0;
      header_bad_next        = 1'b0;
    end else begin
      case (phase)
        PH_ZERO_A: begin
          if (b != 8'd0) begin
            header_bad_next = 1'b1;
          end
          phase_next = PH_ZERO_B;
        end
        PH_ZERO_B: begin
          if (b != 8'd0) begin
            header_bad_next = 1'b1;
          end
          running_crc_next = crc_upd;
          phase_next       = PH_LEN;
        end
        PH_LEN: begin
          payload_length_next = (b == 8'd0) ? MAX_PAYLOAD : {1'b0, b};
          running_crc_next    = crc_upd;
          byte_count_next     = '0;
          phase_next          = PH_DATA;
        end
        PH_DATA: begin
          res.payload_valid = 1'b1;
          res.payload_byte  = b;
          res.payload_index = byte_count[7:0];
          running_crc_next  = crc_upd;
          byte_count_next   = count_inc;
          if (count_inc >= payload_length) begin
            phase_next = PH_CRC_HI;
          end
        end
        PH_CRC_HI: begin
          crc_high_received_next = b;
          phase_next             = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          res.frame_done = 1'b1;
          if (header_bad) begin
            res.frame_status = ST_BAD_HEADER;
          end else if (crc_high_received != running_crc[15:8] || b != running_crc[7:0]) begin
            res.frame_status = ST_BAD_CRC;
          end else begin
            res.frame_status = ST_GOOD;
          end
          phase_next             = PH_HUNT;
          byte_count_next        = '0;
          payload_length_next    = '0;
          running_crc_next       = '0;
          crc_high_received_next = '0;
          header_bad_next        = 1'b0;
        end
        default: begin
          if (b == START_BYTE) begin
            phase_next             = PH_ZERO_A;
            byte_count_next        = '0;
            payload_length_next    = '0;
            running_crc_next       = '0;
            crc_high_received_next = '0;
            header_bad_next        = 1'b0;
          end else begin
            phase_next = PH_HUNT;
          end
        end
      endcase
    end
  end

  a_done_returns_to_hunt: assert property (@(posedge clk) disable iff (rst)
    step && res.frame_done |=> phase == PH_HUNT)
    else $error("frame end did not return to hunting");

  a_payload_only_in_data: assert property (@(posedge clk) disable iff (rst)
    step && res.payload_valid |-> phase == PH_DATA && item.action == ACT_BYTE)
    else $error("payload item outside data phase");

  a_data_count_in_range: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> byte_count < payload_length)
    else $error("payload count ran past length");

endmodule

`default_nettype wire

// ===== rtl/crc16_ack_frame_checker_core.sv =====
`default_nettype none
// Reply-frame checker: takes one received serial byte (or a restart) per input
// item and returns exactly one result item for each.
// Input channel in_valid/in_ready/in_data carries action and rx_byte; output
// channel out_valid/out_ready/out_data carries the payload byte with its index
// and, on the low CRC byte, the frame verdict (good, bad header, CRC mismatch).
// Frame: start byte 0x02, two zero bytes, length (0 means 256), payload, then a
// big-endian CRC-16 (poly 0x1021, init 0) over the second zero byte, the
// length and the payload.
// Latency: the result is presented in the cycle after the item is accepted.
// Throughput: one item per cycle while the receiver does not stall; the byte-wide CRC
// update and phase logic sit between the accepting edge and the result register.
// Reset (rst, synchronous) returns to hunting with an empty result register.
// When the receiver stalls, the result register holds and in_ready stays high
// only while that register is empty or being drained in the same cycle.
module crc16_ack_frame_checker_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire crcfc_pkg::in_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output crcfc_pkg::out_t      out_data
);
  import crcfc_pkg::*;

  logic step;
  out_t res;

  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  crcfc_fsm u_fsm (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (in_data),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= res;
    end
  end

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("accepted item produced no result");

  a_restart_result_zero: assert property (@(posedge clk) disable iff (rst)
    step && in_data.action == ACT_RESTART |=> out_data == '0)
    else $error("restart result not all zero");

  a_empty_means_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

`default_nettype wire

// ===== verif/crcfc_frame_monitor.sv =====
`default_nettype none

package crcfc_tb_pkg;

  function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ crcfc_pkg::CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

module crcfc_frame_monitor
  import crcfc_pkg::*;
  import crcfc_tb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic in_ready,
  input  wire in_t  in_data,
  input  wire logic out_valid,
  input  wire logic out_ready,
  input  wire out_t out_data,
  output int        fail_count,
  output int        pending
);

  phase_t      ph;
  logic [8:0]  pay_taken;
  logic [8:0]  pay_len;
  logic [15:0] crc_acc;
  logic [7:0]  crc_hi_seen;
  logic        hdr_bad;
  out_t        reply_q[$];
  int          errors = 0;

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task automatic drop_frame();
    ph          = PH_HUNT;
    pay_taken   = '0;
    pay_len     = '0;
    crc_acc     = '0;
    crc_hi_seen = '0;
    hdr_bad     = 1'b0;
  endtask

  task automatic step_frame(input in_t item, output out_t reply);
    logic [7:0] b;
    b     = item.rx_byte;
    reply = '0;
    if (item.action == ACT_RESTART) begin
      drop_frame();
      return;
    end
    case (ph)
      PH_ZERO_A: begin
        if (b != 8'h00) hdr_bad = 1'b1;
        ph = PH_ZERO_B;
      end
      PH_ZERO_B: begin
        if (b != 8'h00) hdr_bad = 1'b1;
        crc_acc = crc16_step(crc_acc, b);
        ph      = PH_LEN;
      end
      PH_LEN: begin
        pay_len   = (b == 8'h00) ? MAX_PAYLOAD : {1'b0, b};
        crc_acc   = crc16_step(crc_acc, b);
        pay_taken = '0;
        ph        = PH_DATA;
      end
      PH_DATA: begin
        reply.payload_valid = 1'b1;
        reply.payload_byte  = b;
        reply.payload_index = pay_taken[7:0];
        crc_acc             = crc16_step(crc_acc, b);
        pay_taken           = pay_taken + 9'd1;
        if (pay_taken >= pay_len) ph = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        crc_hi_seen = b;
        ph          = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        reply.frame_done = 1'b1;
        if (hdr_bad) begin
          reply.frame_status = ST_BAD_HEADER;
        end else if (crc_hi_seen != crc_acc[15:8] || b != crc_acc[7:0]) begin
          reply.frame_status = ST_BAD_CRC;
        end else begin
          reply.frame_status = ST_GOOD;
        end
        drop_frame();
      end
      default: begin
        if (b == START_BYTE) begin
          drop_frame();
          ph = PH_ZERO_A;
        end else begin
          ph = PH_HUNT;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    out_t got;
    out_t want;
    out_t next_reply;
    if (rst) begin
      drop_frame();
      reply_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = out_data;
        if (reply_q.size() == 0) begin
          report($sformatf("result %h with nothing expected", got));
        end else begin
          want = reply_q.pop_front();
          if (got.payload_valid !== want.payload_valid)
            report($sformatf("payload_valid got %b want %b",
                             got.payload_valid, want.payload_valid));
          if (got.payload_byte !== want.payload_byte)
            report($sformatf("payload_byte got %h want %h",
                             got.payload_byte, want.payload_byte));
          if (got.payload_index !== want.payload_index)
            report($sformatf("payload_index got %0d want %0d",
                             got.payload_index, want.payload_index));
          if (got.frame_done !== want.frame_done)
            report($sformatf("frame_done got %b want %b",
                             got.frame_done, want.frame_done));
          if (got.frame_status !== want.frame_status)
            report($sformatf("frame_status got %0d want %0d",
                             got.frame_status, want.frame_status));
        end
      end
      if (in_valid && in_ready) begin
        step_frame(in_data, next_reply);
        reply_q.push_back(next_reply);
      end
    end
    fail_count <= errors;
    pending    <= reply_q.size();
  end

endmodule

`default_nettype wire

// ===== verif/tb_crc16_ack_frame_checker_core.sv =====
`default_nettype none

module tb_crc16_ack_frame_checker_core;
  import crcfc_pkg::*;
  import crcfc_tb_pkg::*;

  localparam int ITEM_TARGET = 1300;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 400000;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  out_t out_data;
  int   fail_count;
  int   pending;
  int   sent        = 0;
  int   frame_items = 0;
  bit   quiet       = 1'b0;
  bit   hold_done   = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  crc16_ack_frame_checker_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  crcfc_frame_monitor mon (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    if (r == 2) return START_BYTE;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_item(input logic act, input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_data.action  <= act;
    in_data.rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_frame(input logic [7:0] len_byte, input logic [7:0] hdr_a,
                            input logic [7:0] hdr_b, input bit bad_crc, input int cut_at);
    logic [7:0]  frame[$];
    logic [15:0] acc;
    logic [15:0] mask;
    logic [7:0]  body;
    int          n;
    n     = (len_byte == 8'h00) ? 256 : int'(len_byte);
    acc   = crc16_step(16'h0000, hdr_b);
    acc   = crc16_step(acc, len_byte);
    frame = '{START_BYTE, hdr_a, hdr_b, len_byte};
    for (int i = 0; i < n; i++) begin
      body = pick_byte();
      acc  = crc16_step(acc, body);
      frame.push_back(body);
    end
    if (bad_crc) begin
      mask = 16'($urandom_range(1, 65535));
      acc  = acc ^ mask;
    end
    frame.push_back(acc[15:8]);
    frame.push_back(acc[7:0]);
    foreach (frame[i]) begin
      if (i == cut_at) begin
        send_item(ACT_RESTART, pick_byte());
        frame_items++;
        return;
      end
      send_item(ACT_BYTE, frame[i]);
      frame_items++;
    end
  endtask

  // receiver: random back-pressure, one long hold-off while the sender keeps offering
  initial begin
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (!hold_done && sent >= 400) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int         r;
    int         lr;
    int         n;
    int         cut;
    int         burst;
    logic [7:0] len;
    logic [7:0] ha;
    logic [7:0] hb;
    bit         bad;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // hunting noise and restart
    send_item(ACT_BYTE, 8'h55);
    send_item(ACT_BYTE, 8'hFF);
    send_item(ACT_RESTART, START_BYTE);
    // good, bad header with bad CRC, bad CRC, restart mid-frame
    send_frame(8'd1, 8'h00, 8'h00, 1'b0, -1);
    send_frame(8'd1, 8'h01, 8'h80, 1'b1, -1);
    send_frame(8'd1, 8'h00, 8'h00, 1'b1, -1);
    send_frame(8'd1, 8'h00, 8'h00, 1'b0, 2);
    // zero length byte: full payload
    send_frame(8'h00, 8'h00, 8'h00, 1'b0, -1);

    while (frame_items < ITEM_TARGET) begin
      if ($urandom_range(0, 19) == 0) quiet = !quiet;
      r = $urandom_range(0, 99);
      if (r < 72) begin
        lr = $urandom_range(0, 99);
        if (lr < 70) len = 8'($urandom_range(1, 8));
        else if (lr < 95) len = 8'($urandom_range(9, 40));
        else if (lr < 98) len = 8'hFF;
        else len = 8'h00;
        n   = (len == 8'h00) ? 256 : int'(len);
        ha  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
        hb  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
        bad = ($urandom_range(0, 6) == 0);
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, n + 5) : -1;
        send_frame(len, ha, hb, bad, cut);
      end else if (r < 85) begin
        repeat ($urandom_range(1, 4)) send_item(ACT_BYTE, pick_byte());
      end else if (r < 92) begin
        send_item(ACT_RESTART, 8'($urandom_range(0, 255)));
        frame_items++;
      end else begin
        burst = $urandom_range(2, 8);
        repeat (burst) begin
          send_item(($urandom_range(0, 5) == 0) ? ACT_RESTART : ACT_BYTE, pick_byte());
        end
        frame_items += burst;
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
